@@ rtl/enmm_pkg.sv @@
// shared types, constants and helper functions for the neighbor match mask core
package enmm_pkg;

	localparam int IMG_WIDTH = 128;
	localparam int IMG_HEIGHT = 128;
	localparam int COORD_W = 7;
	localparam int TIME_W = 32;
	localparam int DELTA_W = TIME_W + 1;
	localparam int WIN_W = 16;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;

	localparam int PIX_DEPTH = 2 * IMG_WIDTH * IMG_HEIGHT;
	localparam int PIX_AW = $clog2(PIX_DEPTH);

	localparam int NB_COUNT = 8;
	localparam int MASK_W = NB_COUNT;
	localparam int HIST_DEPTH = 1 << MASK_W;
	localparam int HIST_AW = MASK_W;

	// signed neighbor coordinate, wide enough for the largest image edge plus sign
	localparam int NB_W = 12;

	typedef struct packed {
		logic rd;
		logic wr_time;
		logic wr_flag;
		logic flag_data;
		logic [PIX_AW-1:0] addr;
		logic [TIME_W-1:0] time_data;
	} pix_req_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic [HIST_AW-1:0] addr;
		logic [TIME_W-1:0] wdata;
	} hist_req_t;

	typedef struct packed {
		logic signed [1:0] dx;
		logic signed [1:0] dy;
	} nb_offset_t;

	// scan order: dx outer, dy inner, centre skipped
	function automatic nb_offset_t nb_offset(input logic [2:0] pos);
		nb_offset_t o;
		case (pos)
			3'd0: o = '{dx: -2'sd1, dy: -2'sd1};
			3'd1: o = '{dx: -2'sd1, dy: 2'sd0};
			3'd2: o = '{dx: -2'sd1, dy: 2'sd1};
			3'd3: o = '{dx: 2'sd0, dy: -2'sd1};
			3'd4: o = '{dx: 2'sd0, dy: 2'sd1};
			3'd5: o = '{dx: 2'sd1, dy: -2'sd1};
			3'd6: o = '{dx: 2'sd1, dy: 2'sd0};
			default: o = '{dx: 2'sd1, dy: 2'sd1};
		endcase
		return o;
	endfunction

	// store address of one pixel and polarity
	function automatic logic [PIX_AW-1:0] cell_of(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic pol);
		return PIX_AW'((int'(y) * IMG_WIDTH + int'(x)) * 2 + int'(pol));
	endfunction

endpackage

@@ rtl/enmm_pixel_store.sv @@
// single-port pixel store: latest timestamp and event flag per pixel and polarity
module enmm_pixel_store import enmm_pkg::*; (
	input logic clk,
	input pix_req_t req,
	output logic [TIME_W-1:0] rd_time,
	output logic rd_flag
);

	logic [TIME_W-1:0] time_mem [PIX_DEPTH];
	logic flag_mem [PIX_DEPTH];
	logic [TIME_W-1:0] rd_time_q;
	logic rd_flag_q;

	always_ff @(posedge clk) begin
		if (req.wr_time) begin
			time_mem[req.addr] <= req.time_data;
		end
		if (req.wr_flag) begin
			flag_mem[req.addr] <= req.flag_data;
		end
		if (req.rd) begin
			rd_time_q <= time_mem[req.addr];
			rd_flag_q <= flag_mem[req.addr];
		end
	end

	assign rd_time = rd_time_q;
	assign rd_flag = rd_flag_q;

endmodule

@@ rtl/enmm_hist_mem.sv @@
// mask histogram memory with per-bin valid bits so reset reads as zero
module enmm_hist_mem import enmm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input hist_req_t req,
	output logic [TIME_W-1:0] count
);

	logic [TIME_W-1:0] mem [HIST_DEPTH];
	logic [HIST_DEPTH-1:0] valid_q;
	logic [TIME_W-1:0] rdata_q;
	logic rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.wr) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.rd) begin
				rvalid_q <= valid_q[req.addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign count = rvalid_q ? rdata_q : '0;

endmodule

@@ rtl/enmm_delta_unit.sv @@
// shared time difference and running minimum compare
module enmm_delta_unit import enmm_pkg::*; (
	input logic [TIME_W-1:0] ts,
	input logic [TIME_W-1:0] stored,
	input logic signed [DELTA_W-1:0] cur_min,
	output logic signed [DELTA_W-1:0] delta,
	output logic lower
);

	assign delta = $signed({1'b0, ts} - {1'b0, stored});
	assign lower = delta < cur_min;

endmodule

@@ rtl/event_neighbor_match_mask_core.sv @@
// top level: event neighbor match sequencer with pixel store and mask histogram
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    func timestamp x_coord y_coord polarity bin_index
//  output    out        out_valid / out_stall  match_found match_x match_y neighbor_mask
//                                              min_delta hist_count
//  config    in         cfg_we                 cfg_data (match_window)
//
// an in-image event runs a store step, a neighbor scan (up to eight neighbor reads on the
// single pixel port, each compared in the cycle after its read, then a drain step), a histogram
// read and a histogram write, a result step and the idle step that takes the request
// a histogram read request skips the store, the scan and the histogram write
// after reset the event flags are cleared one entry a cycle, all 32768 entries, with
// in_stall high; configuration writes are taken throughout
// a new request is taken while an earlier result still waits under out_stall; the
// sequencer then holds in its result cycle until the output register frees up
module event_neighbor_match_mask_core import enmm_pkg::*; (
	input logic clk,
	input logic arst_n,
	// configuration
	input logic cfg_we,
	input logic [WIN_W-1:0] cfg_data,
	// input channel
	input logic in_valid,
	output logic in_stall,
	input logic func,
	input logic [TIME_W-1:0] timestamp,
	input logic [COORD_W-1:0] x_coord,
	input logic [COORD_W-1:0] y_coord,
	input logic polarity,
	input logic [7:0] bin_index,
	// output channel
	output logic out_valid,
	input logic out_stall,
	output logic match_found,
	output logic [COORD_W-1:0] match_x,
	output logic [COORD_W-1:0] match_y,
	output logic [MASK_W-1:0] neighbor_mask,
	output logic signed [DELTA_W-1:0] min_delta,
	output logic [TIME_W-1:0] hist_count
);

	// sequencer state codes
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_STORE = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_HREAD = 3'd4;
	localparam logic [2:0] ST_HWRITE = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;
	logic [PIX_AW-1:0] clr_q;
	logic [WIN_W-1:0] window_q;

	// captured request
	logic func_q;
	logic [TIME_W-1:0] ts_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic pol_q;
	logic [7:0] bin_q;

	// running match result
	logic signed [DELTA_W-1:0] min_q;
	logic [MASK_W-1:0] mask_q;
	logic found_q;
	logic [COORD_W-1:0] bx_q;
	logic [COORD_W-1:0] by_q;

	// scan counter, one neighbor issued per count, count 8 drains the compare
	logic [3:0] scan_q;

	// compare stage, in the cycle after the read issue
	logic rd_s1;
	logic [2:0] pos_s1;
	logic [COORD_W-1:0] nx_s1;
	logic [COORD_W-1:0] ny_s1;

	// output register
	logic out_valid_q;
	logic found_out_q;
	logic [COORD_W-1:0] mx_out_q;
	logic [COORD_W-1:0] my_out_q;
	logic [MASK_W-1:0] mask_out_q;
	logic signed [DELTA_W-1:0] delta_out_q;
	logic [TIME_W-1:0] hist_out_q;

	pix_req_t pix_req;
	hist_req_t hist_req;
	logic [TIME_W-1:0] pix_time;
	logic pix_flag;
	logic [TIME_W-1:0] hist_cnt;
	logic signed [DELTA_W-1:0] cmp_delta;
	logic cmp_lower;

	nb_offset_t nb_off;
	logic signed [NB_W-1:0] nx_w;
	logic signed [NB_W-1:0] ny_w;
	logic nb_inb;
	logic issue;
	logic in_take;
	logic out_free;
	logic in_image;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_image = (int'(x_coord) < IMG_WIDTH) && (int'(y_coord) < IMG_HEIGHT);

	// neighbor coordinate for the current scan position
	assign nb_off = nb_offset(scan_q[2:0]);
	assign nx_w = $signed({{(NB_W-COORD_W){1'b0}}, x_q})
		+ {{(NB_W-2){nb_off.dx[1]}}, nb_off.dx};
	assign ny_w = $signed({{(NB_W-COORD_W){1'b0}}, y_q})
		+ {{(NB_W-2){nb_off.dy[1]}}, nb_off.dy};
	assign nb_inb = !nx_w[NB_W-1] && !ny_w[NB_W-1]
		&& (nx_w[NB_W-2:0] < (NB_W-1)'(IMG_WIDTH))
		&& (ny_w[NB_W-2:0] < (NB_W-1)'(IMG_HEIGHT));
	assign issue = (state_q == ST_SCAN) && !scan_q[3] && nb_inb;

	// pixel port: clear sweep, centre store, neighbor reads
	always_comb begin
		pix_req = '0;
		case (state_q)
			ST_CLEAR: begin
				pix_req.wr_flag = 1'b1;
				pix_req.flag_data = 1'b0;
				pix_req.addr = clr_q;
			end
			ST_STORE: begin
				pix_req.wr_time = 1'b1;
				pix_req.wr_flag = 1'b1;
				pix_req.flag_data = 1'b1;
				pix_req.addr = cell_of(x_q, y_q, pol_q);
				pix_req.time_data = ts_q;
			end
			ST_SCAN: begin
				pix_req.rd = issue;
				pix_req.addr = cell_of(nx_w[COORD_W-1:0], ny_w[COORD_W-1:0], pol_q);
			end
			default: begin
				pix_req = '0;
			end
		endcase
	end

	// histogram port: read the bin, then write it back incremented for events
	always_comb begin
		hist_req = '0;
		case (state_q)
			ST_HREAD: begin
				hist_req.rd = 1'b1;
				hist_req.addr = func_q ? bin_q : mask_q;
			end
			ST_HWRITE: begin
				hist_req.wr = 1'b1;
				hist_req.addr = mask_q;
				// saturating count
				hist_req.wdata = (&hist_cnt) ? hist_cnt : hist_cnt + 1'b1;
			end
			default: begin
				hist_req = '0;
			end
		endcase
	end

	enmm_pixel_store u_pix (
		.clk(clk),
		.req(pix_req),
		.rd_time(pix_time),
		.rd_flag(pix_flag)
	);

	enmm_hist_mem u_hist (
		.clk(clk),
		.arst_n(arst_n),
		.req(hist_req),
		.count(hist_cnt)
	);

	enmm_delta_unit u_delta (
		.ts(ts_q),
		.stored(pix_time),
		.cur_min(min_q),
		.delta(cmp_delta),
		.lower(cmp_lower)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_data;
		end
	end

	// sequencer and control flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			scan_q <= '0;
			rd_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= issue;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PIX_AW'(PIX_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_take) begin
						if (func) begin
							state_q <= ST_HREAD;
						end else if (in_image) begin
							state_q <= ST_STORE;
						end else begin
							// off-image event still counts in bin zero
							state_q <= ST_HREAD;
						end
					end
				end
				ST_STORE: begin
					scan_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q[3]) begin
						state_q <= ST_HREAD;
					end
				end
				ST_HREAD: begin
					state_q <= func_q ? ST_DONE : ST_HWRITE;
				end
				ST_HWRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture, compare stage and result payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q <= func;
			ts_q <= timestamp;
			x_q <= x_coord;
			y_q <= y_coord;
			pol_q <= polarity;
			bin_q <= bin_index;
			min_q <= $signed({{(DELTA_W-WIN_W){1'b0}}, window_q});
			mask_q <= '0;
			found_q <= 1'b0;
			bx_q <= '0;
			by_q <= '0;
		end
		pos_s1 <= scan_q[2:0];
		nx_s1 <= nx_w[COORD_W-1:0];
		ny_s1 <= ny_w[COORD_W-1:0];
		// neighbor holds a same-polarity event below the running minimum
		if (rd_s1 && pix_flag && cmp_lower) begin
			min_q <= cmp_delta;
			mask_q[pos_s1] <= 1'b1;
			found_q <= 1'b1;
			bx_q <= nx_s1;
			by_q <= ny_s1;
		end
		if (state_q == ST_DONE && out_free) begin
			if (func_q) begin
				found_out_q <= 1'b0;
				mx_out_q <= '0;
				my_out_q <= '0;
				mask_out_q <= '0;
				delta_out_q <= '0;
				hist_out_q <= hist_cnt;
			end else begin
				found_out_q <= found_q;
				mx_out_q <= bx_q;
				my_out_q <= by_q;
				mask_out_q <= mask_q;
				delta_out_q <= min_q;
				hist_out_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign match_found = found_out_q;
	assign match_x = mx_out_q;
	assign match_y = my_out_q;
	assign neighbor_mask = mask_out_q;
	assign min_delta = delta_out_q;
	assign hist_count = hist_out_q;

endmodule

@@ rtl/enmm_checker.sv @@
// port-level checker for the neighbor match mask core, bound to the top level
module enmm_checker import enmm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [WIN_W-1:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input logic func,
	input logic [TIME_W-1:0] timestamp,
	input logic [COORD_W-1:0] x_coord,
	input logic [COORD_W-1:0] y_coord,
	input logic polarity,
	input logic [7:0] bin_index,
	input logic out_valid,
	input logic out_stall,
	input logic match_found,
	input logic [COORD_W-1:0] match_x,
	input logic [COORD_W-1:0] match_y,
	input logic [MASK_W-1:0] neighbor_mask,
	input logic signed [DELTA_W-1:0] min_delta,
	input logic [TIME_W-1:0] hist_count
);

	// one request at a time: busy right after a request is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again in the cycle after a request");

	// a waiting result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(neighbor_mask)
			&& $stable(min_delta) && $stable(hist_count) && $stable(match_x))
		else $error("stalled result changed");

	// a result goes away only when taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped without being taken");

	// no match leaves the best neighbor and mask at zero
	a_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !match_found |-> match_x == '0 && match_y == '0
			&& neighbor_mask == '0)
		else $error("match fields set without a match");

	// a histogram count only comes with an otherwise empty result
	a_hist_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hist_count != '0 |-> !match_found && neighbor_mask == '0
			&& min_delta == '0)
		else $error("histogram count mixed with match fields");

endmodule

bind event_neighbor_match_mask_core enmm_checker u_enmm_checker (.*);
